// ===== design/kpsd_pkg.sv =====
// ---------------------------------------------------------------------------
// kpsd_pkg: shared types and constants of the keypad scan debouncer
// matrix width, key code width, no-key marker and event codes
// ---------------------------------------------------------------------------
package kpsd_pkg;

   localparam int MATRIX_WIDTH = 16;
   localparam int KEY_WIDTH    = 5;
   localparam int INDEX_WIDTH  = 4;
   localparam int COUNT_WIDTH  = 8;

   localparam logic [KEY_WIDTH-1:0]   NO_KEY    = 5'd16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 8'd255;

   typedef logic [MATRIX_WIDTH-1:0] matrix_type;
   typedef logic [KEY_WIDTH-1:0]    key_type;
   typedef logic [INDEX_WIDTH-1:0]  index_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_type;

endpackage

// ===== design/kpsd_req_if.sv =====
// ---------------------------------------------------------------------------
// kpsd_req_if: key matrix sample channel
// valid/ready handshake carrying one matrix sample
// ---------------------------------------------------------------------------
interface kpsd_req_if;
   import kpsd_pkg::*;

   logic       valid;
   logic       ready;
   matrix_type key_matrix;

   modport source (output valid, output key_matrix, input ready);
   modport sink   (input valid, input key_matrix, output ready);
endinterface

// ===== design/kpsd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// kpsd_rsp_if: debounce event channel
// valid/ready handshake carrying one event and key index
// ---------------------------------------------------------------------------
interface kpsd_rsp_if;
   import kpsd_pkg::*;

   logic      valid;
   logic      ready;
   event_type event_res;
   index_type key_index;

   modport source (output valid, output event_res, output key_index, input ready);
   modport sink   (input valid, input event_res, input key_index, output ready);
endinterface

// ===== design/kpsd_csr_if.sv =====
// ---------------------------------------------------------------------------
// kpsd_csr_if: threshold register write channel
// valid/ready handshake carrying the debounce threshold
// ---------------------------------------------------------------------------
interface kpsd_csr_if;
   import kpsd_pkg::*;

   logic      valid;
   logic      ready;
   count_type debounce_threshold;

   modport source (output valid, output debounce_threshold, input ready);
   modport sink   (input valid, input debounce_threshold, output ready);
endinterface

// ===== design/kpsd_key_pick.sv =====
// ---------------------------------------------------------------------------
// kpsd_key_pick: scan-order priority encoder
// returns the lowest pressed key index among the populated keys, or no-key
// ---------------------------------------------------------------------------
module kpsd_key_pick #(
   parameter int KEY_COUNT = 16
) (
   input  kpsd_pkg::matrix_type key_matrix,
   output kpsd_pkg::key_type    key
);
   import kpsd_pkg::*;

   matrix_type populated;

   // keys beyond the populated count have no input bit
   always_comb begin
      for (int i = 0; i < MATRIX_WIDTH; i++) begin
         populated[i] = (i < KEY_COUNT);
      end
   end

   // column-major index order means lowest set bit wins
   always_comb begin
      key = NO_KEY;
      for (int i = MATRIX_WIDTH - 1; i >= 0; i--) begin
         if (key_matrix[i] && populated[i]) begin
            key = KEY_WIDTH'(i);
         end
      end
   end
endmodule

// ===== design/keypad_scan_debounce_top.sv =====
// ---------------------------------------------------------------------------
// keypad_scan_debounce_top: 4x4 matrix keypad scanner with debounce
// picks the first pressed key of each sample and reports debounced
// press and release events through a confidence counter
// ---------------------------------------------------------------------------
//
//   channel   direction  payload                         transfer when
//   req_bus   in         key_matrix[15:0]                valid & ready
//   rsp_bus   out        event_res[1:0], key_index[3:0]  valid & ready
//   csr_bus   in         debounce_threshold[7:0]         valid & ready
//
// one sample in, one result out per cycle; encode and counter update sit
// between the sample port and the result register
// result register is a single slot: a new sample is taken whenever the slot
// is empty or is being drained in the same cycle
// a stalled result holds the slot and stops further samples
// synchronous active-high reset empties the slot, clears the debounce state
// and loads threshold 5; outside reset, csr writes are always taken
// ---------------------------------------------------------------------------
module keypad_scan_debounce_top #(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 4
) (
   input logic       clock,
   input logic       reset,
   kpsd_req_if.sink  req_bus,
   kpsd_rsp_if.source rsp_bus,
   kpsd_csr_if.sink  csr_bus
);
   import kpsd_pkg::*;

   // keys past the matrix input width are never sampled
   localparam int KEY_COUNT = (ROWS * COLUMNS < MATRIX_WIDTH) ? ROWS * COLUMNS
                                                             : MATRIX_WIDTH;

   // debounce state
   key_type   candidate_ff, candidate_in;
   logic      held_ff, held_in;
   count_type count_ff, count_in;
   count_type threshold_ff;

   // result slot
   logic      rsp_valid_ff, rsp_valid_in;
   event_type event_ff, event_in;
   index_type index_ff, index_in;

   key_type   sample;
   logic      req_take;
   count_type count_up;
   count_type count_down;

   kpsd_key_pick #(
      .KEY_COUNT (KEY_COUNT)
   ) u_key_pick (
      .key_matrix (req_bus.key_matrix),
      .key        (sample)
   );

   // slot free or draining this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // saturating counter steps
   assign count_up   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;
   assign count_down = (count_ff == '0) ? count_ff : count_ff - 8'd1;

   always_comb begin
      candidate_in = candidate_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      event_in     = EV_NONE;
      index_in     = '0;
      if (sample == candidate_ff) begin
         if (sample != NO_KEY) begin
            if (!held_ff) begin
               // still confirming the candidate
               count_in = count_up;
               if (count_up >= threshold_ff) begin
                  held_in  = 1'b1;
                  event_in = EV_PRESS;
                  index_in = candidate_ff[INDEX_WIDTH-1:0];
               end
            end else begin
               // held key seen again: restore full confidence
               count_in = threshold_ff;
            end
         end
      end else begin
         if (held_ff) begin
            // held key missing: lose confidence, release at zero
            count_in = count_down;
            if (count_down == '0) begin
               held_in      = 1'b0;
               candidate_in = sample;
               event_in     = EV_RELEASE;
            end
         end else begin
            // nothing held: restart on the new candidate
            count_in     = '0;
            candidate_in = sample;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= NO_KEY;
         held_ff      <= 1'b0;
         count_ff     <= '0;
         threshold_ff <= 8'd5;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            candidate_ff <= candidate_in;
            held_ff      <= held_in;
            count_ff     <= count_in;
         end
         if (csr_bus.valid) begin
            threshold_ff <= csr_bus.debounce_threshold;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         event_ff <= event_in;
         index_ff <= index_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.event_res = event_ff;
   assign rsp_bus.key_index = index_ff;

endmodule
